>>> hdl/assert_macros.svh
// Assertion macros used by the splitter top level.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/afs_pkg.sv
// Types, codes and length tables for the AMR storage-file frame splitter.
// No dependencies.
package afs_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_MODE    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOP    = 2'd3
  } afs_phase_t;

  // Byte classes
  localparam logic [1:0] CLS_HEADER  = 2'd0;
  localparam logic [1:0] CLS_MODE    = 2'd1;
  localparam logic [1:0] CLS_PAYLOAD = 2'd2;
  localparam logic [1:0] CLS_DISCARD = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_BAD_WB  = 2'd2;

  localparam logic [3:0] NB_HDR_END_POS = 4'd5;
  localparam logic [3:0] WB_HDR_END_POS = 4'd8;
  localparam logic [7:0] CH_NEWLINE     = 8'h0a;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } afs_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] byte_class;
    logic       is_wideband;
    logic [3:0] frame_type;
    logic       frame_last;
    logic [1:0] status;
  } afs_out_t;

  // Wideband magic "#!AMR-WB\n"; the narrowband magic is its first five bytes plus newline
  function automatic logic [7:0] magic_wb(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h23;
      4'd1:    ch = 8'h21;
      4'd2:    ch = 8'h41;
      4'd3:    ch = 8'h4d;
      4'd4:    ch = 8'h52;
      4'd5:    ch = 8'h2d;
      4'd6:    ch = 8'h57;
      4'd7:    ch = 8'h42;
      4'd8:    ch = CH_NEWLINE;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Narrowband payload length per frame type
  function automatic logic [5:0] nb_len(input logic [3:0] t);
    logic [5:0] len;
    unique case (t)
      4'd0:    len = 6'd12;
      4'd1:    len = 6'd13;
      4'd2:    len = 6'd15;
      4'd3:    len = 6'd17;
      4'd4:    len = 6'd19;
      4'd5:    len = 6'd20;
      4'd6:    len = 6'd26;
      4'd7:    len = 6'd31;
      4'd8:    len = 6'd5;
      4'd9:    len = 6'd6;
      4'd10:   len = 6'd5;
      4'd11:   len = 6'd5;
      default: len = 6'd0;
    endcase
    return len;
  endfunction

  // Wideband payload length per frame type; types 10..14 have none
  function automatic logic [5:0] wb_len(input logic [3:0] t);
    logic [5:0] len;
    unique case (t)
      4'd0:    len = 6'd17;
      4'd1:    len = 6'd23;
      4'd2:    len = 6'd32;
      4'd3:    len = 6'd36;
      4'd4:    len = 6'd40;
      4'd5:    len = 6'd46;
      4'd6:    len = 6'd50;
      4'd7:    len = 6'd58;
      4'd8:    len = 6'd60;
      4'd9:    len = 6'd5;
      default: len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic logic wb_invalid(input logic [3:0] t);
    return (t >= 4'd10) && (t <= 4'd14);
  endfunction

endpackage

>>> hdl/afs_parse.sv
// Parser state and per-byte classification for the frame splitter.
// Depends on afs_pkg.
module afs_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  afs_pkg::afs_in_t item,
  output afs_pkg::afs_out_t result
);
  import afs_pkg::*;

  afs_phase_t phase_r, phase_nxt, phase_eff;
  logic [3:0] hpos_r, hpos_nxt, hpos_eff;
  logic       wide_r, wide_nxt, wide_eff;
  logic [5:0] rem_r, rem_nxt, rem_eff;
  logic [3:0] type_r, type_nxt, type_eff;

  logic [7:0] b;
  logic [3:0] t;
  logic [5:0] len;
  logic       len_bad;
  logic       hdr_nb_end;
  logic       hdr_match;
  logic [1:0] cls;
  logic       last;
  logic [1:0] status;

  // A new file restarts everything before the byte is looked at
  always_comb begin
    if (item.file_start) begin
      phase_eff = PH_HEADER;
      hpos_eff  = '0;
      wide_eff  = 1'b0;
      rem_eff   = '0;
      type_eff  = '0;
    end else begin
      phase_eff = phase_r;
      hpos_eff  = hpos_r;
      wide_eff  = wide_r;
      rem_eff   = rem_r;
      type_eff  = type_r;
    end
  end

  assign b          = item.data_byte;
  assign t          = b[6:3];
  assign len        = wide_eff ? wb_len(t) : nb_len(t);
  assign len_bad    = wide_eff && wb_invalid(t);
  assign hdr_nb_end = (hpos_eff == NB_HDR_END_POS) && (b == CH_NEWLINE);
  assign hdr_match  = (hpos_eff <= WB_HDR_END_POS) && (b == magic_wb(hpos_eff));

  // Next state
  always_comb begin
    phase_nxt = phase_eff;
    hpos_nxt  = hpos_eff;
    wide_nxt  = wide_eff;
    rem_nxt   = rem_eff;
    type_nxt  = type_eff;
    unique case (phase_eff)
      PH_HEADER: begin
        if (hdr_nb_end) begin
          wide_nxt  = 1'b0;
          hpos_nxt  = '0;
          phase_nxt = PH_MODE;
        end else if (hdr_match) begin
          if (hpos_eff == WB_HDR_END_POS) begin
            wide_nxt  = 1'b1;
            hpos_nxt  = '0;
            phase_nxt = PH_MODE;
          end else begin
            hpos_nxt = hpos_eff + 4'd1;
          end
        end else begin
          wide_nxt  = 1'b0;
          phase_nxt = PH_STOP;
        end
      end
      PH_MODE: begin
        type_nxt = t;
        if (len_bad) begin
          phase_nxt = PH_STOP;
        end else if (len != '0) begin
          rem_nxt   = len;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (rem_eff <= 6'd1) begin
          rem_nxt   = '0;
          phase_nxt = PH_MODE;
        end else begin
          rem_nxt = rem_eff - 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs
  always_comb begin
    cls    = CLS_HEADER;
    last   = 1'b0;
    status = ST_OK;
    unique case (phase_eff)
      PH_HEADER: begin
        if (!hdr_nb_end && !hdr_match) status = ST_BAD_HDR;
      end
      PH_MODE: begin
        cls = CLS_MODE;
        if (len_bad) status = ST_BAD_WB;
        else if (len == '0) last = 1'b1;
      end
      PH_PAYLOAD: begin
        cls  = CLS_PAYLOAD;
        last = (rem_eff <= 6'd1);
      end
      default: begin
        cls    = CLS_DISCARD;
        status = wide_eff ? ST_BAD_WB : ST_BAD_HDR;
      end
    endcase
  end

  always_comb begin
    result.byte_out    = b;
    result.byte_class  = cls;
    result.is_wideband = wide_nxt;
    result.frame_type  = type_nxt;
    result.frame_last  = last;
    result.status      = status;
  end

  // State update once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hpos_r  <= '0;
      wide_r  <= 1'b0;
      rem_r   <= '0;
      type_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      wide_r  <= wide_nxt;
      rem_r   <= rem_nxt;
      type_r  <= type_nxt;
    end
  end

endmodule

>>> hdl/amr_file_frame_splitter.sv
// AMR storage-file frame splitter: one result per byte, through the input
// register, then the result register. Throughput one byte per cycle unless
// out_ready stalls; the parser state loop is combinational between the
// two registers. Synchronous active-low reset clears both valid flags and
// the parser state (header phase). Depends on afs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module amr_file_frame_splitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  afs_pkg::afs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output afs_pkg::afs_out_t out_data
);
  import afs_pkg::*;

  logic     in_valid_r;
  afs_in_t  in_data_r;
  logic     out_valid_r;
  afs_out_t out_data_r;
  afs_out_t result;
  logic     out_free;
  logic     step;

  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  afs_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_data_r),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AFS_ASSERT_IMP(a_discard_status, out_valid_r && (out_data_r.byte_class == CLS_DISCARD), out_data_r.status != ST_OK, "discarded byte with ok status")
  `AFS_ASSERT_IMP(a_err_not_last, out_valid_r && (out_data_r.status != ST_OK), !out_data_r.frame_last, "error byte marked frame end")
  `AFS_ASSERT_IMP(a_header_clean, out_valid_r && (out_data_r.byte_class == CLS_HEADER), (out_data_r.frame_type == 4'd0) && !out_data_r.frame_last, "header byte carries frame info")
  `AFS_ASSERT_NXT(a_step_fills, step, out_valid_r, "processed byte lost before result register")

endmodule
